[src/wlap_pkg.sv]
// Shared types, constants and helpers for the weighted Laplacian edge stream unit.
package wlap_pkg;

	localparam int DEF_MAX_WIDTH    = 2048;
	localparam int DEF_MAX_HEIGHT   = 2048;
	localparam int MIN_WIDTH        = 3;
	localparam int MIN_HEIGHT       = 2;
	localparam int DEF_FRAME_WIDTH  = 640;
	localparam int DEF_FRAME_HEIGHT = 480;

	localparam int SAMPLE_W    = 20;
	localparam int EDGE_W      = 13;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 12;

	localparam int ACC_W     = 25;
	localparam int TOT_W     = 28;
	localparam int FRAC_BITS = 8;
	localparam int QUO_W     = TOT_W - FRAC_BITS;
	localparam int RND_BIAS  = (1 << FRAC_BITS) - 1;
	localparam int EDGE_MAX  = 2550;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [EDGE_W-1:0]   edge_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	typedef struct packed {
		logic    vld;
		logic    done;
		sample_t ctr;
		sample_t lft;
		sample_t rgt;
		sample_t top;
		sample_t bot;
	} wlap_win_t;

	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lo,
		input int unsigned hi);
		int unsigned r;
		r = v;
		if (r < lo) r = lo;
		if (r > hi) r = hi;
		return r;
	endfunction

endpackage

[src/weighted_laplacian_edge_stream_unit.sv]
// Top level: frame position control, line stores, neighbor window and edge output.
//
//  channel | dir | handshake          | payload
//  s       | in  | s_tvalid/s_tready  | s_tdata[19:0] sample, s_tuser func (1 = drain)
//  m       | out | m_tvalid/m_tready  | m_tdata[12:0] edge_value, m_tlast frame_done
//  cfg     | in  | cfg_valid/cfg_ready| cfg_index register, cfg_data[11:0] value
//
// One beat per cycle on s while s_tready is high; results pass two registered stages to m.
// Neighbors come from one registered read per line store per beat plus a shift window.
// Line stores are not cleared at reset; there is no clearing pass. Reset and any register
// write restart the frame. A stall on m backs up through two stages before s_tready drops.
module weighted_laplacian_edge_stream_unit import wlap_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // [19:0] sample, rest zero
	input  logic                   s_tuser,   // [0] func
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [12:0] edge_value, rest zero
	output logic                   m_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned RST_W = clamp_dim(DEF_FRAME_WIDTH, MIN_WIDTH, MAX_WIDTH);
	localparam int unsigned RST_H = clamp_dim(DEF_FRAME_HEIGHT, MIN_HEIGHT, MAX_HEIGHT);

	logic [AW-1:0] col_q, wm1_q, wm2_q;
	logic [HW-1:0] row_q, h_q;

	sample_t sample;
	logic    pix_ok, drn_ok, adv, last_col, has_res, prv_par;
	logic [AW-1:0] col_nx, prv_addr;
	logic [HW-1:0] row_nx;

	logic          ram_we [2];
	logic [AW-1:0] ram_raddr [2];
	sample_t       rd_data [2];

	sample_t   col0_q [2];
	sample_t   c_q, l_q;
	sample_t   w_ctr, w_lft, w_rgt, w_top, w_bot;
	wlap_win_t win;
	logic      calc_ready;

	assign sample    = sample_t'(s_tdata[SAMPLE_W-1:0]);
	assign cfg_ready = 1'b1;
	assign s_tready  = calc_ready;

	always_comb begin
		pix_ok   = !s_tuser && (row_q < h_q);
		drn_ok   = s_tuser && (row_q == h_q);
		adv      = s_tvalid && s_tready && (pix_ok || drn_ok);
		last_col = (col_q == wm1_q);
		col_nx   = last_col ? '0 : col_q + 1'b1;
		if (pix_ok) begin
			row_nx  = last_col ? row_q + 1'b1 : row_q;
			has_res = (row_q != '0);
		end else begin
			row_nx  = last_col ? '0 : row_q;
			has_res = 1'b1;
		end
		prv_addr = (col_nx == wm1_q) ? wm2_q : col_nx + 1'b1;
		prv_par  = ~row_q[0];
	end

	for (genvar p = 0; p < 2; p++) begin : g_store
		assign ram_we[p]    = adv && pix_ok && (row_q[0] == 1'(p));
		assign ram_raddr[p] = (row_nx[0] == 1'(p)) ? col_nx : prv_addr;

		wlap_line_ram #(
			.DEPTH(MAX_WIDTH),
			.AW   (AW)
		) u_ram (
			.clk  (clk),
			.we   (ram_we[p]),
			.waddr(col_q),
			.wdata(sample),
			.re   (adv),
			.raddr(ram_raddr[p]),
			.rdata(rd_data[p])
		);
	end

	always_comb begin
		w_rgt = rd_data[prv_par];
		w_ctr = (col_q == '0) ? col0_q[prv_par] : c_q;
		w_lft = (col_q == '0) ? w_rgt : l_q;
		if (!s_tuser && row_q == HW'(1)) begin
			w_top = w_ctr;
		end else begin
			w_top = rd_data[row_q[0]];
		end
		w_bot = s_tuser ? rd_data[row_q[0]] : sample;
	end

	always_comb begin
		win.vld  = adv && has_res;
		win.done = drn_ok && last_col;
		win.ctr  = w_ctr;
		win.lft  = w_lft;
		win.rgt  = w_rgt;
		win.top  = w_top;
		win.bot  = w_bot;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c_q <= w_rgt;
			l_q <= w_ctr;
		end
		if (adv && pix_ok && col_q == '0) begin
			col0_q[row_q[0]] <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			wm1_q <= AW'(RST_W - 1);
			wm2_q <= AW'(RST_W - 2);
			h_q   <= HW'(RST_H);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: begin
					wm1_q <= AW'(clamp_dim(cfg_data, MIN_WIDTH, MAX_WIDTH) - 1);
					wm2_q <= AW'(clamp_dim(cfg_data, MIN_WIDTH, MAX_WIDTH) - 2);
					col_q <= '0;
					row_q <= '0;
				end
				REG_FRAME_HEIGHT: begin
					h_q   <= HW'(clamp_dim(cfg_data, MIN_HEIGHT, MAX_HEIGHT));
					col_q <= '0;
					row_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (adv) begin
			col_q <= col_nx;
			row_q <= row_nx;
		end
	end

	wlap_edge_calc u_calc (
		.clk     (clk),
		.arst_n  (arst_n),
		.win     (win),
		.in_ready(calc_ready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

`ifndef SYNTHESIS
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n) col_q <= wm1_q)
		else $error("column position past row end");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n) row_q <= h_q)
		else $error("row position past frame end");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser && !cfg_valid && row_q == h_q && col_q == wm1_q)
		|=> (row_q == '0 && col_q == '0))
		else $error("frame did not restart after last drain beat");

	a_edge_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[EDGE_W-1:0]) <= EDGE_W'(EDGE_MAX)
		&& $signed(m_tdata[EDGE_W-1:0]) >= EDGE_W'(-EDGE_MAX)))
		else $error("edge value outside clamp range");
`endif

endmodule

[src/wlap_line_ram.sv]
// One line store: single write port, single registered read port.
module wlap_line_ram import wlap_pkg::*; #(
	parameter int DEPTH = DEF_MAX_WIDTH,
	parameter int AW    = $clog2(DEF_MAX_WIDTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  sample_t       wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output sample_t       rdata
);

	sample_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[src/wlap_edge_calc.sv]
// Weighted Laplacian arithmetic in two registered stages; the second is the output beat register.
module wlap_edge_calc import wlap_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wlap_win_t              win,
	output logic                   in_ready,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // [12:0] edge_value, rest zero
	output logic                   m_tlast
);

	logic    vld_s1, vld_s2;
	acc_t    sum_s1;
	sample_t bot_s1;
	logic    done_s1;
	edge_t   edge_s2;
	logic    done_s2;
	logic    adv2;

	acc_t                    sum1_d;
	acc_t                    lap;
	logic signed [TOT_W-1:0] tot;
	logic signed [TOT_W-1:0] rnd;
	logic signed [QUO_W-1:0] quo;
	edge_t                   edge_d;

	assign adv2     = !vld_s2 || m_tready;
	assign in_ready = !vld_s1 || adv2;

	always_comb begin
		sum1_d = ACC_W'(10 * ACC_W'(win.ctr) - 3 * ACC_W'(win.lft) - 3 * ACC_W'(win.rgt)
			- 2 * ACC_W'(win.top));
	end

	always_comb begin
		lap = ACC_W'(sum_s1 - 2 * ACC_W'(bot_s1));
		tot = TOT_W'(6 * TOT_W'(lap));
		rnd = tot + TOT_W'(tot[TOT_W-1] ? RND_BIAS : 0);
		quo = QUO_W'(rnd >>> FRAC_BITS);
		if (quo > QUO_W'(EDGE_MAX)) begin
			edge_d = EDGE_W'(EDGE_MAX);
		end else if (quo < QUO_W'(-EDGE_MAX)) begin
			edge_d = EDGE_W'(-EDGE_MAX);
		end else begin
			edge_d = EDGE_W'(quo);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready) vld_s1 <= win.vld;
			if (adv2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && win.vld) begin
			sum_s1  <= sum1_d;
			bot_s1  <= win.bot;
			done_s1 <= win.done;
		end
		if (adv2 && vld_s1) begin
			edge_s2 <= edge_d;
			done_s2 <= done_s1;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {{(OUT_TDATA_W - EDGE_W){1'b0}}, edge_s2};
	assign m_tlast  = done_s2;

endmodule
